// ===== hdl/aht_pkg.sv =====
// aht_pkg: shared constants, codes and types for the aging host table.
// Used by aht_store, aht_cmp and aging_host_table; depends on nothing.
`default_nettype none
package aht_pkg;

    // table geometry
    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int MAX_RESULTS   = 16;
    localparam int CNT_W         = $clog2(MAX_RESULTS + 1);

    localparam logic [IDX_W-1:0] LAST_IDX    = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [CNT_W-1:0] MAX_RES_CNT = CNT_W'(MAX_RESULTS);

    // dead threshold register
    localparam logic [15:0] THR_RESET = 16'd4;

    // item kinds
    localparam logic KIND_SIGHT  = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    // result status codes
    localparam logic [1:0] ST_REFRESH = 2'd0;
    localparam logic [1:0] ST_INSERT  = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_REPORT  = 2'd3;

    // read response from the table store
    typedef struct packed {
        logic        used;
        logic [31:0] address;
        logic [31:0] seen;
    } t_rd;

    // write request into the table store
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        logic [31:0]      address;
        logic [31:0]      seen;
    } t_wr;

    // compare unit flags
    typedef struct packed {
        logic match;
        logic stale;
    } t_cmp;

endpackage
`default_nettype wire

// ===== hdl/aht_store.sv =====
// aht_store: address and last-seen memories plus per-entry used bits.
// One read port with registered data, one write port; uses aht_pkg.
`default_nettype none
module aht_store
    import aht_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_rd_en,
    input  wire logic [IDX_W-1:0] i_rd_idx,
    input  wire t_wr              i_wr,
    output t_rd                   o_rd
);

    logic [31:0]              r_mem_addr [TABLE_ENTRIES];
    logic [31:0]              r_mem_time [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] r_used;
    logic [31:0]              r_rd_addr;
    logic [31:0]              r_rd_seen;
    logic                     r_rd_used;

    // memory write and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem_addr[i_wr.idx] <= i_wr.address;
            r_mem_time[i_wr.idx] <= i_wr.seen;
        end
        if (i_rd_en) begin
            r_rd_addr <= r_mem_addr[i_rd_idx];
            r_rd_seen <= r_mem_time[i_rd_idx];
        end
    end

    // used bits, cleared on reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used    <= '0;
            r_rd_used <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_used[i_wr.idx] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_used <= r_used[i_rd_idx];
            end
        end
    end

    // read response
    always_comb begin
        o_rd.used    = r_rd_used;
        o_rd.address = r_rd_addr;
        o_rd.seen    = r_rd_seen;
    end

endmodule
`default_nettype wire

// ===== hdl/aht_cmp.sv =====
// aht_cmp: shared compare unit, one table entry per cycle.
// Wrapping age subtract against the dead threshold and address match; uses aht_pkg.
`default_nettype none
module aht_cmp
    import aht_pkg::*;
(
    input  wire logic [31:0] i_key,
    input  wire logic [31:0] i_now,
    input  wire logic [15:0] i_thr,
    input  wire t_rd         i_rd,
    output t_cmp             o_cmp
);

    logic [31:0] age;

    // age modulo 2^32, stale when above the threshold
    always_comb begin
        age         = i_now - i_rd.seen;
        o_cmp.stale = age > {16'd0, i_thr};
        o_cmp.match = i_rd.address == i_key;
    end

endmodule
`default_nettype wire

// ===== hdl/aging_host_table.sv =====
// aging_host_table: top level, sequencer, threshold register and result register.
// Instantiates aht_store and aht_cmp; uses aht_pkg.
//
// A sighting or report item is taken when start is high and busy is low; the
// sequencer then walks the table one entry per cycle through the shared compare
// unit, evaluating each entry in the cycle after the memory read port reads it.
// A sighting that hits a slot ends the walk there; a miss, an insert, a full
// table and every report walk all TABLE_ENTRIES entries. Each result appears on the
// o_ ports for one cycle with o_strobe high, in the cycle after it is settled, and
// cannot be held off: report entries stream out during the walk, the final one
// (o_last high) after busy drops. A sighting's table write lands at its last busy
// cycle. The dead threshold may be written only while busy is low and no result
// is pending; it resets to 4. No clearing pass is needed after reset.
`default_nettype none
module aging_host_table
    import aht_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_kind,
    input  wire logic [31:0] i_host_address,
    input  wire logic [31:0] i_now_seconds,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,
    output logic             o_strobe,
    output logic [1:0]       o_status,
    output logic [3:0]       o_slot,
    output logic             o_entry_valid,
    output logic [31:0]      o_reported_address,
    output logic             o_last
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]       r_state,     n_state;
    logic             r_kind,      n_kind;
    logic [31:0]      r_key,       n_key;
    logic [31:0]      r_now,       n_now;
    logic [15:0]      r_thr;
    logic [IDX_W-1:0] r_issue_idx, n_issue_idx;
    logic             r_issue_done, n_issue_done;
    logic             r_eval_vld,  n_eval_vld;
    logic [IDX_W-1:0] r_eval_idx,  n_eval_idx;
    logic             r_found,     n_found;
    logic [IDX_W-1:0] r_free_idx,  n_free_idx;
    logic             r_match,     n_match;
    logic [IDX_W-1:0] r_match_idx, n_match_idx;
    logic             r_pend,      n_pend;
    logic [IDX_W-1:0] r_pend_idx,  n_pend_idx;
    logic [31:0]      r_pend_addr, n_pend_addr;
    logic [CNT_W-1:0] r_cnt,       n_cnt;

    logic             r_out_stb;
    logic [1:0]       r_out_status;
    logic [3:0]       r_out_slot;
    logic             r_out_valid;
    logic [31:0]      r_out_addr;
    logic             r_out_last;

    logic             emit;
    logic [1:0]       e_status;
    logic [3:0]       e_slot;
    logic             e_valid;
    logic [31:0]      e_addr;
    logic             e_last;

    logic             rd_en;
    t_wr              wr;
    t_rd              rd;
    t_cmp             cmp;

    aht_store u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_en  (rd_en),
        .i_rd_idx (r_issue_idx),
        .i_wr     (wr),
        .o_rd     (rd)
    );

    aht_cmp u_cmp (
        .i_key (r_key),
        .i_now (r_now),
        .i_thr (r_thr),
        .i_rd  (rd),
        .o_cmp (cmp)
    );

    // sequencer next state
    always_comb begin
        n_state      = r_state;
        n_kind       = r_kind;
        n_key        = r_key;
        n_now        = r_now;
        n_issue_idx  = r_issue_idx;
        n_issue_done = r_issue_done;
        n_eval_vld   = r_eval_vld;
        n_eval_idx   = r_eval_idx;
        n_found      = r_found;
        n_free_idx   = r_free_idx;
        n_match      = r_match;
        n_match_idx  = r_match_idx;
        n_pend       = r_pend;
        n_pend_idx   = r_pend_idx;
        n_pend_addr  = r_pend_addr;
        n_cnt        = r_cnt;
        rd_en        = 1'b0;
        wr.en        = 1'b0;
        wr.idx       = r_free_idx;
        wr.address   = r_key;
        wr.seen      = r_now;
        emit         = 1'b0;
        e_status     = ST_REPORT;
        e_slot       = 4'd0;
        e_valid      = 1'b0;
        e_addr       = 32'd0;
        e_last       = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state      = S_SCAN;
                    n_kind       = i_kind;
                    n_key        = i_host_address;
                    n_now        = i_now_seconds;
                    n_issue_idx  = '0;
                    n_issue_done = 1'b0;
                    n_eval_vld   = 1'b0;
                    n_found      = 1'b0;
                    n_match      = 1'b0;
                    n_pend       = 1'b0;
                    n_cnt        = '0;
                end
            end
            S_SCAN: begin
                // read issue, one entry per cycle
                n_eval_vld = 1'b0;
                if (!r_issue_done) begin
                    rd_en      = 1'b1;
                    n_eval_vld = 1'b1;
                    n_eval_idx = r_issue_idx;
                    if (r_issue_idx == LAST_IDX) begin
                        n_issue_done = 1'b1;
                    end else begin
                        n_issue_idx = r_issue_idx + 1'b1;
                    end
                end
                // evaluate the entry read last cycle
                if (r_eval_vld) begin
                    if (r_kind == KIND_SIGHT) begin
                        if (rd.used && cmp.match) begin
                            n_match     = 1'b1;
                            n_match_idx = r_eval_idx;
                            n_state     = S_DONE;
                        end else begin
                            if (!r_found && (!rd.used || cmp.stale)) begin
                                n_found    = 1'b1;
                                n_free_idx = r_eval_idx;
                            end
                            if (r_eval_idx == LAST_IDX) begin
                                n_state = S_DONE;
                            end
                        end
                    end else begin
                        if (rd.used && !cmp.stale && (r_cnt < MAX_RES_CNT)) begin
                            // a later live entry: the held one is not last
                            if (r_pend) begin
                                emit     = 1'b1;
                                e_status = ST_REPORT;
                                e_slot   = 4'(r_pend_idx);
                                e_valid  = 1'b1;
                                e_addr   = r_pend_addr;
                                e_last   = 1'b0;
                            end
                            n_pend      = 1'b1;
                            n_pend_idx  = r_eval_idx;
                            n_pend_addr = rd.address;
                            n_cnt       = r_cnt + 1'b1;
                        end
                        if (r_eval_idx == LAST_IDX) begin
                            n_state = S_DONE;
                        end
                    end
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
                emit    = 1'b1;
                e_last  = 1'b1;
                if (r_kind == KIND_SIGHT) begin
                    if (r_match) begin
                        wr.en    = 1'b1;
                        wr.idx   = r_match_idx;
                        e_status = ST_REFRESH;
                        e_slot   = 4'(r_match_idx);
                    end else if (r_found) begin
                        wr.en    = 1'b1;
                        wr.idx   = r_free_idx;
                        e_status = ST_INSERT;
                        e_slot   = 4'(r_free_idx);
                    end else begin
                        e_status = ST_FULL;
                    end
                end else if (r_pend) begin
                    e_status = ST_REPORT;
                    e_slot   = 4'(r_pend_idx);
                    e_valid  = 1'b1;
                    e_addr   = r_pend_addr;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_thr        <= THR_RESET;
            r_issue_done <= 1'b0;
            r_eval_vld   <= 1'b0;
            r_found      <= 1'b0;
            r_match      <= 1'b0;
            r_pend       <= 1'b0;
            r_cnt        <= '0;
            r_out_stb    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_issue_done <= n_issue_done;
            r_eval_vld   <= n_eval_vld;
            r_found      <= n_found;
            r_match      <= n_match;
            r_pend       <= n_pend;
            r_cnt        <= n_cnt;
            r_out_stb    <= emit;
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_kind      <= n_kind;
        r_key       <= n_key;
        r_now       <= n_now;
        r_issue_idx <= n_issue_idx;
        r_eval_idx  <= n_eval_idx;
        r_free_idx  <= n_free_idx;
        r_match_idx <= n_match_idx;
        r_pend_idx  <= n_pend_idx;
        r_pend_addr <= n_pend_addr;
        if (emit) begin
            r_out_status <= e_status;
            r_out_slot   <= e_slot;
            r_out_valid  <= e_valid;
            r_out_addr   <= e_addr;
            r_out_last   <= e_last;
        end
    end

    assign busy               = r_state != S_IDLE;
    assign o_strobe           = r_out_stb;
    assign o_status           = r_out_status;
    assign o_slot             = r_out_slot;
    assign o_entry_valid      = r_out_valid;
    assign o_reported_address = r_out_addr;
    assign o_last             = r_out_last;

    // an accepted item keeps the block busy next cycle
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("item accepted but block not busy");

    // a non-final result only streams out while the block is still busy
    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |-> busy)
        else $error("non-final result after the walk ended");

    // sighting results are always single and final
    a_sight_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status != ST_REPORT) |-> o_last)
        else $error("sighting result without last");

    // an empty report is a lone final result
    a_empty_rep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status == ST_REPORT && !o_entry_valid) |-> (o_last && o_slot == 4'd0))
        else $error("empty report result malformed");

    // a full table touches no entry
    a_full_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status == ST_FULL) |-> (o_slot == 4'd0 && !$past(wr.en)))
        else $error("table full result with write or slot");

endmodule
`default_nettype wire
